### rtl/pmp_pkg.sv
// ----------------------------------------------------------------------------
// pmp_pkg
// Types, constants and tables shared by the particle motion predictor.
// ----------------------------------------------------------------------------
package pmp_pkg;

   localparam int CORDIC_STAGES_DEF = 24;
   localparam int CORDIC_MAX        = 32;

   localparam longint PI_Q28      = 843314857;
   localparam longint TWO_PI_Q28  = 1686629714;
   localparam longint HALF_PI_Q28 = 421657428;
   localparam longint GAIN_Q30    = 652032874;

   // angle reduction: offset by a multiple of 2*pi, then conditional subtracts
   localparam int     WRAP_STEPS = 14;
   localparam int     WRAP_W     = 45;
   localparam longint WRAP_OFF   = TWO_PI_Q28 << (WRAP_STEPS - 1);

   localparam int XY_W   = 34;
   localparam int Z_W    = 33;
   localparam int DIFF_W = XY_W + 1;
   localparam int PROD_W = 32 + DIFF_W;
   localparam int QUO_W  = 34;
   localparam int NUM_W  = PROD_W;
   localparam int DEN_W  = 38;
   localparam int CMP_W  = DEN_W + QUO_W;
   localparam int STR_W  = 45;
   localparam int SUM_W  = 48;

   localparam logic [30:0] TS_RESET  = 31'd1677722;
   localparam logic [30:0] THR_RESET = 31'd168;

   localparam logic [7:0] CSR_VELOCITY  = 8'd0;
   localparam logic [7:0] CSR_YAW_RATE  = 8'd1;
   localparam logic [7:0] CSR_TIME_STEP = 8'd2;
   localparam logic [7:0] CSR_THRESHOLD = 8'd3;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] heading;
      logic        [31:0] weight;
      logic signed [31:0] noise_x;
      logic signed [31:0] noise_y;
      logic signed [31:0] noise_heading;
   } req_type;

   typedef struct packed {
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      logic signed [31:0] new_heading;
      logic        [31:0] new_weight;
      logic               turned;
   } rsp_type;

   function automatic int atan_q28(input int idx);
      int r;
      case (idx)
         0:  r = 210828714;
         1:  r = 124459457;
         2:  r = 65760959;
         3:  r = 33381290;
         4:  r = 16755422;
         5:  r = 8385879;
         6:  r = 4193963;
         7:  r = 2097109;
         8:  r = 1048571;
         9:  r = 524287;
         10: r = 262144;
         11: r = 131072;
         12: r = 65536;
         13: r = 32768;
         14: r = 16384;
         15: r = 8192;
         16: r = 4096;
         17: r = 2048;
         18: r = 1024;
         19: r = 512;
         20: r = 256;
         21: r = 128;
         22: r = 64;
         23: r = 32;
         24: r = 16;
         25: r = 8;
         26: r = 4;
         27: r = 2;
         28: r = 1;
         default: r = 0;
      endcase
      return r;
   endfunction

endpackage

### rtl/pmp_wrap_cell.sv
// ----------------------------------------------------------------------------
// pmp_wrap_cell
// One angle reduction step: subtract 2*pi << SHIFT when it fits.
// ----------------------------------------------------------------------------
module pmp_wrap_cell #(
   parameter int SHIFT = 0
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [pmp_pkg::WRAP_W-1:0]  din,
   output logic [pmp_pkg::WRAP_W-1:0]  dout
);
   import pmp_pkg::*;

   localparam logic [WRAP_W-1:0] SUB = WRAP_W'(TWO_PI_Q28) << SHIFT;

   logic [WRAP_W-1:0] u_ff, u_in;

   always_comb begin
      u_in = (din >= SUB) ? din - SUB : din;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff <= u_in;
      end
   end

   assign dout = u_ff;
endmodule

### rtl/pmp_cordic_cell.sv
// ----------------------------------------------------------------------------
// pmp_cordic_cell
// One rotation-mode CORDIC iteration with floor shifts.
// ----------------------------------------------------------------------------
module pmp_cordic_cell #(
   parameter int IDX = 0
) (
   input  logic                             clock,
   input  logic                             en,
   input  logic signed [pmp_pkg::XY_W-1:0]  x_i,
   input  logic signed [pmp_pkg::XY_W-1:0]  y_i,
   input  logic signed [pmp_pkg::Z_W-1:0]   z_i,
   output logic signed [pmp_pkg::XY_W-1:0]  x_o,
   output logic signed [pmp_pkg::XY_W-1:0]  y_o,
   output logic signed [pmp_pkg::Z_W-1:0]   z_o
);
   import pmp_pkg::*;

   localparam logic signed [Z_W-1:0] ANG = Z_W'(atan_q28(IDX));

   logic signed [XY_W-1:0] x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [Z_W-1:0]  z_ff, z_in;

   always_comb begin
      xs = x_i >>> IDX;
      ys = y_i >>> IDX;
      if (z_i >= 0) begin
         x_in = x_i - ys;
         y_in = y_i + xs;
         z_in = z_i - ANG;
      end else begin
         x_in = x_i + ys;
         y_in = y_i - xs;
         z_in = z_i + ANG;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign x_o = x_ff;
   assign y_o = y_ff;
   assign z_o = z_ff;
endmodule

### rtl/pmp_div_cell.sv
// ----------------------------------------------------------------------------
// pmp_div_cell
// One restoring division step producing quotient bit K.
// ----------------------------------------------------------------------------
module pmp_div_cell #(
   parameter int K = 0
) (
   input  logic                        clock,
   input  logic                        en,
   input  logic [pmp_pkg::DEN_W-1:0]   dmag,
   input  logic [pmp_pkg::NUM_W-1:0]   rem_i,
   input  logic [pmp_pkg::QUO_W-1:0]   q_i,
   output logic [pmp_pkg::NUM_W-1:0]   rem_o,
   output logic [pmp_pkg::QUO_W-1:0]   q_o
);
   import pmp_pkg::*;

   logic [CMP_W-1:0] sub, wide;
   logic             ge;
   logic [NUM_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] q_ff, q_in;

   always_comb begin
      sub    = CMP_W'(dmag) << K;
      wide   = CMP_W'(rem_i);
      ge     = wide >= sub;
      rem_in = ge ? NUM_W'(wide - sub) : rem_i;
      q_in   = ge ? (q_i | (QUO_W'(1) << K)) : q_i;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         q_ff   <= q_in;
      end
   end

   assign rem_o = rem_ff;
   assign q_o   = q_ff;
endmodule

### rtl/particle_motion_predict.sv
// ----------------------------------------------------------------------------
// particle_motion_predict
// CTRV pose prediction for a particle filter: two CORDIC cell chains,
// angle reduction cells and restoring divider cells in one pipeline.
//
// channel  direction  beat
// req_     in         one particle pose plus noise samples
// rsp_     out        predicted pose, weight, turned flag
// csr_     in         register write, no wait, no read-back
//
// One beat per cycle unless the pipeline stalls; the pipeline depth is set by
// the CORDIC chain and the 34 divider cells in each divider chain.
// Reset is synchronous, clears the valid pipeline and loads the registers with their reset values.
// The whole pipeline stalls only when its last stage and the output
// register both hold a beat and rsp_ready is low.
// ----------------------------------------------------------------------------
module particle_motion_predict #(
   parameter int CORDIC_STAGES = pmp_pkg::CORDIC_STAGES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pmp_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pmp_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic [7:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   import pmp_pkg::*;

   localparam int N   = (CORDIC_STAGES > CORDIC_MAX) ? CORDIC_MAX : CORDIC_STAGES;
   localparam int S_B = 1;
   localparam int S_W = S_B + WRAP_STEPS;
   localparam int S_F = S_W + 1;
   localparam int S_C = S_F + N;
   localparam int S_G = S_C + 1;
   localparam int S_H = S_G + 1;
   localparam int S_I = S_H + 1;
   localparam int S_D = S_I + QUO_W;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] noise_x;
      logic signed [31:0] noise_y;
      logic        [31:0] weight;
      logic               turned;
   } side_type;

   typedef struct packed {
      logic signed [STR_W-1:0] dxs;
      logic signed [STR_W-1:0] dys;
      logic                    ovf_x;
      logic                    ovf_y;
      logic                    sgn_x;
      logic                    sgn_y;
   } post_type;

   function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [31:0] r;
      if (v > SUM_W'(64'sd2147483647)) begin
         r = 32'sh7fffffff;
      end else if (v < -SUM_W'(64'sd2147483648)) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // registers
   logic signed [31:0] vel_ff, yaw_ff;
   logic        [30:0] ts_ff, thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vel_ff <= '0;
         yaw_ff <= '0;
         ts_ff  <= TS_RESET;
         thr_ff <= THR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_VELOCITY:  vel_ff <= csr_wdata;
            CSR_YAW_RATE:  yaw_ff <= csr_wdata;
            CSR_TIME_STEP: ts_ff  <= csr_wdata[30:0];
            CSR_THRESHOLD: thr_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   logic [31:0]      yaw_mag;
   logic [DEN_W-1:0] dmag;
   assign yaw_mag = yaw_ff[31] ? 32'(-yaw_ff) : 32'(yaw_ff);
   assign dmag    = {yaw_mag, 6'b0};

   // flow control
   logic [S_D:0] valid_ff;
   logic         out_valid_ff;
   rsp_type      out_ff, result_c;
   logic         en;

   assign en        = !valid_ff[S_D] || !out_valid_ff || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = out_valid_ff;
   assign rsp_payload = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            valid_ff <= {valid_ff[S_D-1:0], req_valid};
         end
         if (en && valid_ff[S_D]) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en && valid_ff[S_D]) begin
         out_ff <= result_c;
      end
   end

   // stage A
   logic signed [63:0] prod_c, prod_ff;
   logic signed [31:0] h0_ff, nh_ff;
   logic               turn_c;
   side_type           side_ff [S_D+1];
   side_type           side_c;

   always_comb begin
      prod_c = yaw_ff * $signed({1'b0, ts_ff});
      turn_c = yaw_mag > {1'b0, thr_ff};
      side_c.pos_x   = req_payload.pos_x;
      side_c.pos_y   = req_payload.pos_y;
      side_c.noise_x = req_payload.noise_x;
      side_c.noise_y = req_payload.noise_y;
      side_c.weight  = req_payload.weight;
      side_c.turned  = turn_c;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff    <= prod_c;
         h0_ff      <= req_payload.heading;
         nh_ff      <= req_payload.noise_heading;
         side_ff[0] <= side_c;
         for (int k = 1; k <= S_D; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // stage B
   logic signed [WRAP_W:0] a0_c, a1_c, a2_c, th_c;
   logic [WRAP_W-1:0]      ub_c [3];
   logic [WRAP_W-1:0]      ub_ff [3];

   always_comb begin
      a0_c = (WRAP_W+1)'(h0_ff);
      a1_c = a0_c + (WRAP_W+1)'($signed(prod_ff[63:20]));
      th_c = side_ff[0].turned ? a1_c : a0_c;
      a2_c = th_c + (WRAP_W+1)'(nh_ff);
      ub_c[0] = WRAP_W'(a0_c + (WRAP_W+1)'(PI_Q28 + WRAP_OFF));
      ub_c[1] = WRAP_W'(a1_c + (WRAP_W+1)'(PI_Q28 + WRAP_OFF));
      ub_c[2] = WRAP_W'(a2_c + (WRAP_W+1)'(PI_Q28 + WRAP_OFF));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ub_ff <= ub_c;
      end
   end

   // angle reduction cells
   logic [WRAP_W-1:0] wv [3][WRAP_STEPS+1];

   for (genvar c = 0; c < 3; c++) begin : g_wrap
      assign wv[c][0] = ub_ff[c];
      for (genvar j = 0; j < WRAP_STEPS; j++) begin : g_step
         pmp_wrap_cell #(.SHIFT(WRAP_STEPS - 1 - j)) u_cell (
            .clock (clock),
            .en    (en),
            .din   (wv[c][j]),
            .dout  (wv[c][j+1])
         );
      end
   end

   // stage F: fold the two CORDIC angles into [-pi/2, pi/2]
   logic signed [Z_W-1:0] zw_c [3];
   logic signed [Z_W-1:0] zf_c [2];
   logic signed [Z_W-1:0] zf_ff [2];
   logic [1:0]            neg_c;
   logic [1:0]            neg_ff [S_F:S_C];
   logic signed [31:0]    head_ff [S_F:S_D];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         zw_c[c] = $signed({2'b0, wv[c][WRAP_STEPS][30:0]}) - Z_W'(PI_Q28);
      end
      for (int c = 0; c < 2; c++) begin
         if (zw_c[c] > Z_W'(HALF_PI_Q28)) begin
            zf_c[c]  = zw_c[c] - Z_W'(PI_Q28);
            neg_c[c] = 1'b1;
         end else if (zw_c[c] < -Z_W'(HALF_PI_Q28)) begin
            zf_c[c]  = zw_c[c] + Z_W'(PI_Q28);
            neg_c[c] = 1'b1;
         end else begin
            zf_c[c]  = zw_c[c];
            neg_c[c] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         zf_ff        <= zf_c;
         neg_ff[S_F]  <= neg_c;
         head_ff[S_F] <= zw_c[2][31:0];
         for (int k = S_F + 1; k <= S_C; k++) begin
            neg_ff[k] <= neg_ff[k-1];
         end
         for (int k = S_F + 1; k <= S_D; k++) begin
            head_ff[k] <= head_ff[k-1];
         end
      end
   end

   // CORDIC cell chains
   logic signed [XY_W-1:0] cx [2][N+1];
   logic signed [XY_W-1:0] cy [2][N+1];
   logic signed [Z_W-1:0]  cz [2][N+1];

   for (genvar c = 0; c < 2; c++) begin : g_cordic
      assign cx[c][0] = XY_W'(GAIN_Q30);
      assign cy[c][0] = '0;
      assign cz[c][0] = zf_ff[c];
      for (genvar j = 0; j < N; j++) begin : g_iter
         pmp_cordic_cell #(.IDX(j)) u_cell (
            .clock (clock),
            .en    (en),
            .x_i   (cx[c][j]),
            .y_i   (cy[c][j]),
            .z_i   (cz[c][j]),
            .x_o   (cx[c][j+1]),
            .y_o   (cy[c][j+1]),
            .z_o   (cz[c][j+1])
         );
      end
   end

   // stage G
   logic signed [XY_W-1:0] s_ff [2];
   logic signed [XY_W-1:0] co_ff [2];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 2; c++) begin
            s_ff[c]  <= neg_ff[S_C][c] ? -cy[c][N] : cy[c][N];
            co_ff[c] <= neg_ff[S_C][c] ? -cx[c][N] : cx[c][N];
         end
      end
   end

   // stage H
   logic signed [DIFF_W-1:0] mx_c, my_c;
   logic signed [PROD_W-1:0] px_c, py_c, px_ff, py_ff;

   always_comb begin
      if (side_ff[S_G].turned) begin
         mx_c = DIFF_W'(s_ff[1]) - DIFF_W'(s_ff[0]);
         my_c = DIFF_W'(co_ff[0]) - DIFF_W'(co_ff[1]);
      end else begin
         mx_c = DIFF_W'(co_ff[0]);
         my_c = DIFF_W'(s_ff[0]);
      end
      px_c = PROD_W'(vel_ff) * PROD_W'(mx_c);
      py_c = PROD_W'(vel_ff) * PROD_W'(my_c);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff <= px_c;
         py_ff <= py_c;
      end
   end

   // stage I
   logic signed [68:0] tx_c, ty_c;
   logic [NUM_W-1:0]   nmx_c, nmy_c;
   logic [NUM_W-1:0]   nm_ff [2];
   post_type           post_c;
   post_type           post_ff [S_I:S_D];

   always_comb begin
      tx_c = 69'($signed(px_ff[PROD_W-1:30])) * 69'($signed({1'b0, ts_ff}));
      ty_c = 69'($signed(py_ff[PROD_W-1:30])) * 69'($signed({1'b0, ts_ff}));
      nmx_c = px_ff[PROD_W-1] ? NUM_W'(-px_ff) : NUM_W'(px_ff);
      nmy_c = py_ff[PROD_W-1] ? NUM_W'(-py_ff) : NUM_W'(py_ff);
      post_c.dxs   = $signed(tx_c[68:24]);
      post_c.dys   = $signed(ty_c[68:24]);
      post_c.ovf_x = CMP_W'(nmx_c) >= (CMP_W'(dmag) << QUO_W);
      post_c.ovf_y = CMP_W'(nmy_c) >= (CMP_W'(dmag) << QUO_W);
      post_c.sgn_x = px_ff[PROD_W-1] ^ yaw_ff[31];
      post_c.sgn_y = py_ff[PROD_W-1] ^ yaw_ff[31];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nm_ff[0]     <= nmx_c;
         nm_ff[1]     <= nmy_c;
         post_ff[S_I] <= post_c;
         for (int k = S_I + 1; k <= S_D; k++) begin
            post_ff[k] <= post_ff[k-1];
         end
      end
   end

   // divider cell chains
   logic [NUM_W-1:0] dr [2][QUO_W+1];
   logic [QUO_W-1:0] dq [2][QUO_W+1];

   for (genvar c = 0; c < 2; c++) begin : g_div
      assign dr[c][0] = nm_ff[c];
      assign dq[c][0] = '0;
      for (genvar j = 0; j < QUO_W; j++) begin : g_bit
         pmp_div_cell #(.K(QUO_W - 1 - j)) u_cell (
            .clock (clock),
            .en    (en),
            .dmag  (dmag),
            .rem_i (dr[c][j]),
            .q_i   (dq[c][j]),
            .rem_o (dr[c][j+1]),
            .q_o   (dq[c][j+1])
         );
      end
   end

   // final sums
   logic [QUO_W:0]          magx_c, magy_c;
   logic signed [QUO_W+1:0] darcx_c, darcy_c;
   logic signed [SUM_W-1:0] dx_c, dy_c, sumx_c, sumy_c;

   always_comb begin
      magx_c = post_ff[S_D].ovf_x ? ((QUO_W+1)'(1) << QUO_W) : {1'b0, dq[0][QUO_W]};
      magy_c = post_ff[S_D].ovf_y ? ((QUO_W+1)'(1) << QUO_W) : {1'b0, dq[1][QUO_W]};
      darcx_c = post_ff[S_D].sgn_x ? -$signed({1'b0, magx_c}) : $signed({1'b0, magx_c});
      darcy_c = post_ff[S_D].sgn_y ? -$signed({1'b0, magy_c}) : $signed({1'b0, magy_c});
      if (side_ff[S_D].turned) begin
         dx_c = SUM_W'(darcx_c);
         dy_c = SUM_W'(darcy_c);
      end else begin
         dx_c = SUM_W'(post_ff[S_D].dxs);
         dy_c = SUM_W'(post_ff[S_D].dys);
      end
      sumx_c = SUM_W'(side_ff[S_D].pos_x) + dx_c + SUM_W'(side_ff[S_D].noise_x);
      sumy_c = SUM_W'(side_ff[S_D].pos_y) + dy_c + SUM_W'(side_ff[S_D].noise_y);
      result_c.new_x       = sat32(sumx_c);
      result_c.new_y       = sat32(sumy_c);
      result_c.new_heading = head_ff[S_D];
      result_c.new_weight  = side_ff[S_D].weight;
      result_c.turned      = side_ff[S_D].turned;
   end
endmodule

### rtl/pmp_checker.sv
// ----------------------------------------------------------------------------
// pmp_checker
// Port-level checks on the particle motion predictor, bound to the top.
// ----------------------------------------------------------------------------
module pmp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pmp_pkg::rsp_type rsp_payload
);
   import pmp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat dropped or changed while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid)
      else $error("req stalled with empty output");

   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (longint'(rsp_payload.new_heading) >= -PI_Q28) &&
                    (longint'(rsp_payload.new_heading) < PI_Q28))
      else $error("heading not wrapped");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");
endmodule

bind particle_motion_predict pmp_checker u_pmp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

### tb/sv/particle_motion_predict_checker.sv
// ----------------------------------------------------------------------------
// particle_motion_predict_checker
// Watches the req_, rsp_ and csr_ ports of the particle motion predictor,
// keeps its own copy of the motion registers, predicts the pose for every
// accepted request beat under the CTRV model with a bit-exact CORDIC, and
// compares each accepted response beat with the oldest predicted pose.
// ----------------------------------------------------------------------------
module particle_motion_predict_checker #(
   parameter int CORDIC_STAGES = pmp_pkg::CORDIC_STAGES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  pmp_pkg::req_type req_payload,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  pmp_pkg::rsp_type rsp_payload,
   input  logic             csr_we,
   input  logic [7:0]       csr_index,
   input  logic [31:0]      csr_wdata,
   output int               fail_count,
   output int               poses_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import pmp_pkg::*;

   localparam longint ARCTAN [32] = '{
      210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
      2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};

   longint  speed, turn_rate, interval, thresh;
   rsp_type pose_queue[$];

   assign poses_pending = pose_queue.size();

   function automatic longint wrap_heading(input longint a);
      longint r;
      r = (a + PI_Q28) % TWO_PI_Q28;
      if (r < 0) r += TWO_PI_Q28;
      return r - PI_Q28;
   endfunction

   function automatic void cordic_sincos(input longint ang, output longint s,
                                         output longint c);
      longint z, x, y, xs, ys;
      bit     flip;
      z = wrap_heading(ang);
      x = GAIN_Q30;
      y = 0;
      flip = 0;
      if (z > HALF_PI_Q28) begin
         z -= PI_Q28;
         flip = 1;
      end else if (z < -HALF_PI_Q28) begin
         z += PI_Q28;
         flip = 1;
      end
      for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys;
            y += xs;
            z -= ARCTAN[i];
         end else begin
            x += ys;
            y -= xs;
            z += ARCTAN[i];
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   function automatic logic [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic rsp_type predict_pose(input req_type p);
      rsp_type r;
      longint  h0, dx, dy, th, s0, c0, s1, c1, wd, mag;
      bit      arc;
      h0 = longint'(p.heading);
      mag = turn_rate < 0 ? -turn_rate : turn_rate;
      arc = mag > thresh;
      cordic_sincos(h0, s0, c0);
      if (arc) begin
         wd = (turn_rate * interval) >>> 20;
         cordic_sincos(h0 + wd, s1, c1);
         dx = (speed * (s1 - s0)) / (turn_rate * 64);
         dy = (speed * (c0 - c1)) / (turn_rate * 64);
         th = h0 + wd;
      end else begin
         dx = (((speed * c0) >>> 30) * interval) >>> 24;
         dy = (((speed * s0) >>> 30) * interval) >>> 24;
         th = h0;
      end
      r.new_x       = clamp32(longint'(p.pos_x) + dx + longint'(p.noise_x));
      r.new_y       = clamp32(longint'(p.pos_y) + dy + longint'(p.noise_y));
      r.new_heading = 32'(wrap_heading(th + longint'(p.noise_heading)));
      r.new_weight  = p.weight;
      r.turned      = arc;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         speed      <= 0;
         turn_rate  <= 0;
         interval   <= longint'(TS_RESET);
         thresh     <= longint'(THR_RESET);
         fail_count <= 0;
         pose_queue.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_VELOCITY:  speed     <= longint'(signed'(csr_wdata));
               CSR_YAW_RATE:  turn_rate <= longint'(signed'(csr_wdata));
               CSR_TIME_STEP: interval  <= longint'(csr_wdata[30:0]);
               CSR_THRESHOLD: thresh    <= longint'(csr_wdata[30:0]);
               default: ;
            endcase
         end
         if (req_valid && req_ready) pose_queue.push_back(predict_pose(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (pose_queue.size() == 0) begin
               $error("response beat with no pose pending");
               fail_count <= fail_count + 1;
            end else begin
               want = pose_queue.pop_front();
               if (rsp_payload != want) fail_count <= fail_count + 1;
               if (rsp_payload.new_x != want.new_x)
                  $error("new_x expected %0d actual %0d", want.new_x, rsp_payload.new_x);
               if (rsp_payload.new_y != want.new_y)
                  $error("new_y expected %0d actual %0d", want.new_y, rsp_payload.new_y);
               if (rsp_payload.new_heading != want.new_heading)
                  $error("new_heading expected %0d actual %0d", want.new_heading,
                         rsp_payload.new_heading);
               if (rsp_payload.new_weight != want.new_weight)
                  $error("new_weight expected %0h actual %0h", want.new_weight,
                         rsp_payload.new_weight);
               if (rsp_payload.turned != want.turned)
                  $error("turned expected %0b actual %0b", want.turned,
                         rsp_payload.turned);
            end
         end
      end
   end

endmodule

### tb/sv/tb_particle_motion_predict.sv
// ----------------------------------------------------------------------------
// tb_particle_motion_predict
// Drives the particle motion predictor with directed edge poses and about
// 950 random poses over many register settings, with bursty request beats
// and a stalling response side; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_particle_motion_predict;
   timeunit 1ns;
   timeprecision 1ps;
   import pmp_pkg::*;

   localparam logic [7:0] CSR_SPARE = 8'd7;
   localparam int DRAIN_CYCLES = CORDIC_STAGES_DEF + 80;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_we;
   logic [7:0]  csr_index;
   logic [31:0] csr_wdata;
   int          fail_count;
   int          poses_pending;
   int          stall_left = 0;
   int          stall_mode = 0;

   particle_motion_predict dut (.*);
   particle_motion_predict_checker chk (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         stall_left = $urandom_range(20, 200);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= $urandom_range(0, 1);
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic drain_poses();
      req_valid = 1'b0;
      while (poses_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_motion(input logic [31:0] v, input logic [31:0] w,
                             input logic [31:0] ts, input logic [31:0] thr);
      drain_poses();
      write_reg(CSR_VELOCITY, v);
      write_reg(CSR_YAW_RATE, w);
      write_reg(CSR_TIME_STEP, ts);
      write_reg(CSR_THRESHOLD, thr);
   endtask

   // valid stays high on return; caller lowers it for a gap
   task automatic send_pose(input req_type p);
      req_payload = p;
      req_valid   = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic idle_gap(input int n);
      if (n > 0) begin
         req_valid = 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   function automatic logic [31:0] pick_angle();
      case ($urandom_range(0, 4))
         0: return 32'(PI_Q28) - $urandom_range(0, 3);
         1: return -32'(PI_Q28) + $urandom_range(0, 3) - 1;
         2: return 32'(HALF_PI_Q28) + $urandom_range(0, 4) - 2;
         3: return 32'($urandom_range(0, 2 * PI_Q28) - PI_Q28);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] pick_pos();
      case ($urandom_range(0, 3))
         0: return 32'h7fffffff - $urandom_range(0, 1 << 20);
         1: return 32'h80000000 + $urandom_range(0, 1 << 20);
         2: return $urandom_range(0, 1 << 24) - (1 << 23);
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type random_pose();
      req_type p;
      p.pos_x         = pick_pos();
      p.pos_y         = pick_pos();
      p.heading       = pick_angle();
      p.weight        = $urandom;
      p.noise_x       = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4095) - 2048;
      p.noise_y       = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4095) - 2048;
      p.noise_heading = $urandom_range(0, 3) == 0 ? $urandom : pick_angle();
      return p;
   endfunction

   function automatic req_type edge_pose(input int k);
      req_type p;
      p = '0;
      case (k)
         0: begin
            p.pos_x = 32'h7fffffff; p.pos_y = 32'h7fffffff;
            p.noise_x = 32'h7fffffff; p.noise_y = 32'h7fffffff;
            p.weight = 32'hffffffff; p.heading = 32'(PI_Q28) - 1;
         end
         1: begin
            p.pos_x = 32'h80000000; p.pos_y = 32'h80000000;
            p.noise_x = 32'h80000000; p.noise_y = 32'h80000000;
            p.heading = -32'(PI_Q28);
         end
         2: begin
            p.heading = 32'h7fffffff; p.noise_heading = 32'h7fffffff;
         end
         3: begin
            p.heading = 32'h80000000; p.noise_heading = 32'h80000000;
            p.weight = 32'h5a5a5a5a;
         end
         default: p = random_pose();
      endcase
      return p;
   endfunction

   task automatic edge_phase(input logic [31:0] v, input logic [31:0] w,
                             input logic [31:0] ts, input logic [31:0] thr);
      set_motion(v, w, ts, thr);
      for (int k = 0; k < 3; k++) send_pose(edge_pose((k == 2) ? $urandom_range(0, 3) : k));
      idle_gap(1);
   endtask

   function automatic logic [31:0] pick_reg(input logic [31:0] hi, input logic [31:0] lo,
                                            input logic [31:0] typ);
      case ($urandom_range(0, 5))
         0: return hi;
         1: return lo;
         2, 3: return typ;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int sent;
      int burst;
      req_type p;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_we      = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // reset register values first
      for (int k = 0; k < 4; k++) send_pose(edge_pose(k));
      idle_gap(2);
      edge_phase(32'h7fffffff, 32'd168, 32'h7fffffff, 32'd168);
      edge_phase(32'h80000000, 32'd169, 32'h7fffffff, 32'd168);
      edge_phase(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
      edge_phase(32'h80000000, 32'h7fffffff, 32'd0, 32'd0);
      edge_phase(32'h00010000, 32'd1, 32'd1677722, 32'd0);
      edge_phase(32'h00010000, 32'hffffffff, 32'd1677722, 32'd0);
      drain_poses();
      write_reg(CSR_SPARE, 32'hffffffff);
      send_pose(edge_pose(0));
      idle_gap(1);

      sent = 0;
      while (sent < 950) begin
         set_motion(pick_reg(32'h7fffffff, 32'h80000000, $urandom_range(0, 1 << 22)),
                    pick_reg(32'h7fffffff, 32'h80000000,
                             $urandom_range(0, 1 << 26) - (1 << 25)),
                    pick_reg(32'h7fffffff, 32'd0, $urandom_range(0, 1 << 25)),
                    pick_reg(32'h7fffffff, 32'd0, $urandom_range(0, 1 << 16)));
         for (int n = 0; n < 60 && sent < 950; ) begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst; b++) begin
               p = random_pose();
               send_pose(p);
               n++;
               sent++;
            end
            if (sent == 400) begin
               idle_gap(1);
               while (poses_pending != 0) @(negedge clock);
            end
            idle_gap($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6));
         end
      end
      idle_gap(1);
      while (poses_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && poses_pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### particle_motion_predict.f
rtl/pmp_pkg.sv
rtl/pmp_wrap_cell.sv
rtl/pmp_cordic_cell.sv
rtl/pmp_div_cell.sv
rtl/particle_motion_predict.sv
rtl/pmp_checker.sv
tb/sv/particle_motion_predict_checker.sv
tb/sv/tb_particle_motion_predict.sv
